// ----- rtl/core/obtob_pkg.sv -----
package obtob_pkg;

   typedef struct packed {
      logic        side;
      logic [31:0] price;
      logic [31:0] amount;
      logic        end_of_update;
      logic [47:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic [31:0] best_bid_price;
      logic [31:0] best_bid_amount;
      logic        bid_present;
      logic [31:0] best_ask_price;
      logic [31:0] best_ask_amount;
      logic        ask_present;
      logic [47:0] report_time;
      logic        table_full;
   } rsp_type;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam int ENTRY_W = 64;

endpackage

// ----- rtl/core/obtob_ram.sv -----
module obtob_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/order_book_top_of_book_top.sv -----
// Top-of-book tracker. Each req_ transaction is one level update (side, price,
// amount); a transaction with end_of_update set also produces one rsp_
// transaction with the best bid, best ask and status flags. Levels for each
// side live in a single-port-read RAM of LEVELS entries (price and amount),
// with per-entry used bits in flops. An update sweeps its side's RAM one entry
// per cycle to find a matching price or the lowest free slot. A report then
// sweeps both RAMs in parallel for the best levels. The next request is taken
// once the update is applied or, for a report, once the result is parked in
// the output register.
module order_book_top_of_book_top #(
   parameter int LEVELS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  obtob_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output obtob_pkg::rsp_type rsp_data
);
   import obtob_pkg::*;

   localparam int AW = $clog2(LEVELS);
   localparam int CW = AW + 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_APPLY = 5'b00100,
      ST_BEST  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic          rv_ff, rv_in;
   logic [LEVELS-1:0] bid_used_ff, bid_used_in;
   logic [LEVELS-1:0] ask_used_ff, ask_used_in;
   logic          hit_ff, hit_in, free_ff, free_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic          full_ff, full_in;
   logic          bf_ff, bf_in, af_ff, af_in;
   logic [31:0]   bp_ff, bp_in, ba_ff, ba_in, ap_ff, ap_in, aa_ff, aa_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic             bwe, awe;
   logic [AW-1:0]    waddr;
   logic [ENTRY_W-1:0] wdata, brd, ard;
   logic [AW-1:0]    raddr;
   logic [AW-1:0]    ridx;

   assign raddr = cnt_ff[AW-1:0];
   assign ridx  = rcnt_ff[AW-1:0];

   obtob_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_bid (
      .clock, .wr_en(bwe), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(brd));

   obtob_ram #(.WIDTH(ENTRY_W), .DEPTH(LEVELS)) u_ask (
      .clock, .wr_en(awe), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(ard));

   logic [ENTRY_W-1:0] srd;
   logic [LEVELS-1:0]  sused;
   assign srd   = (req_ff.side == SIDE_ASK) ? ard : brd;
   assign sused = (req_ff.side == SIDE_ASK) ? ask_used_ff : bid_used_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      rcnt_in      = rcnt_ff;
      rv_in        = 1'b0;
      bid_used_in  = bid_used_ff;
      ask_used_in  = ask_used_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      hit_idx_in   = hit_idx_ff;
      free_idx_in  = free_idx_ff;
      full_in      = full_ff;
      bf_in = bf_ff; af_in = af_ff;
      bp_in = bp_ff; ba_in = ba_ff; ap_in = ap_ff; aa_in = aa_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      bwe   = 1'b0;
      awe   = 1'b0;
      waddr = hit_ff ? hit_idx_ff : free_idx_ff;
      wdata = {req_ff.price, req_ff.amount};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cnt_in   = '0;
               rcnt_in  = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(LEVELS)) begin
               cnt_in = cnt_ff + 1'b1;
               rv_in  = 1'b1;
            end
            rcnt_in = cnt_ff;
            if (rv_ff) begin
               if (sused[ridx]) begin
                  if (!hit_in && srd[63:32] == req_ff.price) begin
                     hit_in     = 1'b1;
                     hit_idx_in = ridx;
                  end
               end else if (!free_in) begin
                  free_in     = 1'b1;
                  free_idx_in = ridx;
               end
            end
            if (!rv_ff && cnt_ff == CW'(LEVELS)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (req_ff.amount == '0) begin
               if (hit_ff) begin
                  if (req_ff.side == SIDE_ASK) ask_used_in[hit_idx_ff] = 1'b0;
                  else bid_used_in[hit_idx_ff] = 1'b0;
               end
            end else if (hit_ff || free_ff) begin
               if (req_ff.side == SIDE_ASK) begin
                  awe = 1'b1;
                  ask_used_in[waddr] = 1'b1;
               end else begin
                  bwe = 1'b1;
                  bid_used_in[waddr] = 1'b1;
               end
            end else begin
               full_in = 1'b1;
            end
            cnt_in  = '0;
            bf_in   = 1'b0;
            af_in   = 1'b0;
            bp_in   = '0; ba_in = '0; ap_in = '0; aa_in = '0;
            state_in = req_ff.end_of_update ? ST_BEST : ST_IDLE;
         end
         ST_BEST: begin
            if (cnt_ff < CW'(LEVELS)) begin
               cnt_in = cnt_ff + 1'b1;
               rv_in  = 1'b1;
            end
            rcnt_in = cnt_ff;
            if (rv_ff) begin
               if (bid_used_ff[ridx] && (!bf_ff || brd[63:32] > bp_ff)) begin
                  bf_in = 1'b1; bp_in = brd[63:32]; ba_in = brd[31:0];
               end
               if (ask_used_ff[ridx] && (!af_ff || ard[63:32] < ap_ff)) begin
                  af_in = 1'b1; ap_in = ard[63:32]; aa_in = ard[31:0];
               end
            end
            if (!rv_ff && cnt_ff == CW'(LEVELS)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.best_bid_price  = bp_ff;
               rsp_in.best_bid_amount = ba_ff;
               rsp_in.bid_present     = bf_ff;
               rsp_in.best_ask_price  = ap_ff;
               rsp_in.best_ask_amount = aa_ff;
               rsp_in.ask_present     = af_ff;
               rsp_in.report_time     = req_ff.time_stamp;
               rsp_in.table_full      = full_ff;
               full_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rv_ff        <= 1'b0;
         bid_used_ff  <= '0;
         ask_used_ff  <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         bid_used_ff  <= bid_used_in;
         ask_used_ff  <= ask_used_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      cnt_ff      <= cnt_in;
      rcnt_ff     <= rcnt_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      bf_ff <= bf_in; af_ff <= af_in;
      bp_ff <= bp_in; ba_ff <= ba_in; ap_ff <= ap_in; aa_ff <= aa_in;
      rsp_ff      <= rsp_in;
   end

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPLY) |-> !(bwe || awe)) else $error("ram write outside apply");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(bwe && awe)) else $error("both tables written");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("stray response");
   a_present_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (bf_ff == 1'b0 || bid_used_ff != '0))
      else $error("bid flag without levels");

endmodule

// ----- tb/tb_order_book_top_of_book_top.sv -----
`timescale 1ns / 1ps

class book_scoreboard;
   localparam int LV = 256;
   logic [31:0] bid_px[LV];
   logic [31:0] bid_amt[LV];
   bit          bid_used[LV];
   logic [31:0] ask_px[LV];
   logic [31:0] ask_amt[LV];
   bit          ask_used[LV];
   bit          full_seen;
   obtob_pkg::rsp_type pending[$];
   int          errors;

   function void clear();
      foreach (bid_used[k]) begin
         bid_used[k] = 0;
         ask_used[k] = 0;
      end
      full_seen = 0;
      pending.delete();
      errors = 0;
   endfunction

   function void note_update(obtob_pkg::req_type r);
      int hit;
      int free_slot;
      obtob_pkg::rsp_type e;
      hit = -1;
      free_slot = -1;
      for (int k = 0; k < LV; k++) begin
         if (r.side == obtob_pkg::SIDE_BID ? bid_used[k] : ask_used[k]) begin
            if (hit < 0 && (r.side == obtob_pkg::SIDE_BID ? bid_px[k] : ask_px[k]) == r.price)
               hit = k;
         end else if (free_slot < 0) begin
            free_slot = k;
         end
      end
      if (r.amount == 0) begin
         if (hit >= 0) begin
            if (r.side == obtob_pkg::SIDE_BID) bid_used[hit] = 0;
            else ask_used[hit] = 0;
         end
      end else if (hit >= 0) begin
         if (r.side == obtob_pkg::SIDE_BID) bid_amt[hit] = r.amount;
         else ask_amt[hit] = r.amount;
      end else if (free_slot >= 0) begin
         if (r.side == obtob_pkg::SIDE_BID) begin
            bid_px[free_slot] = r.price;
            bid_amt[free_slot] = r.amount;
            bid_used[free_slot] = 1;
         end else begin
            ask_px[free_slot] = r.price;
            ask_amt[free_slot] = r.amount;
            ask_used[free_slot] = 1;
         end
      end else begin
         full_seen = 1;
      end
      if (!r.end_of_update) return;
      e = '0;
      for (int k = 0; k < LV; k++) begin
         if (bid_used[k] && (!e.bid_present || bid_px[k] > e.best_bid_price)) begin
            e.best_bid_price = bid_px[k];
            e.best_bid_amount = bid_amt[k];
            e.bid_present = 1;
         end
         if (ask_used[k] && (!e.ask_present || ask_px[k] < e.best_ask_price)) begin
            e.best_ask_price = ask_px[k];
            e.best_ask_amount = ask_amt[k];
            e.ask_present = 1;
         end
      end
      e.report_time = r.time_stamp;
      e.table_full = full_seen;
      full_seen = 0;
      pending.insert(pending.size(), e);
   endfunction

   function void check_report(obtob_pkg::rsp_type a);
      obtob_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected report transaction");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.best_bid_price !== e.best_bid_price) begin
         $error("best_bid_price exp %h got %h", e.best_bid_price, a.best_bid_price); errors++;
      end
      if (a.best_bid_amount !== e.best_bid_amount) begin
         $error("best_bid_amount exp %h got %h", e.best_bid_amount, a.best_bid_amount); errors++;
      end
      if (a.bid_present !== e.bid_present) begin
         $error("bid_present exp %b got %b", e.bid_present, a.bid_present); errors++;
      end
      if (a.best_ask_price !== e.best_ask_price) begin
         $error("best_ask_price exp %h got %h", e.best_ask_price, a.best_ask_price); errors++;
      end
      if (a.best_ask_amount !== e.best_ask_amount) begin
         $error("best_ask_amount exp %h got %h", e.best_ask_amount, a.best_ask_amount); errors++;
      end
      if (a.ask_present !== e.ask_present) begin
         $error("ask_present exp %b got %b", e.ask_present, a.ask_present); errors++;
      end
      if (a.report_time !== e.report_time) begin
         $error("report_time exp %h got %h", e.report_time, a.report_time); errors++;
      end
      if (a.table_full !== e.table_full) begin
         $error("table_full exp %b got %b", e.table_full, a.table_full); errors++;
      end
   endfunction
endclass

module tb_order_book_top_of_book_top;
   import obtob_pkg::*;

   localparam longint CYCLE_LIMIT = 64'd8_000_000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   book_scoreboard board;
   longint  cycles;
   bit      quiet;
   bit      hold_rsp;
   int      price_base;

   order_book_top_of_book_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   task automatic send_update(logic side, logic [31:0] price, logic [31:0] amount,
                              logic eou);
      req_type r;
      r.side = side;
      r.price = price;
      r.amount = amount;
      r.end_of_update = eou;
      r.time_stamp = 48'({$urandom, $urandom});
      while (!quiet && $urandom_range(99) < 25) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_update(r);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_price();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return price_base + $urandom_range(40);
      endcase
   endfunction

   function automatic logic [31:0] pick_amount();
      case ($urandom_range(9))
         0, 1, 2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) board.check_report(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 0;
      else rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
   end

   initial begin
      board = new();
      board.clear();
      cycles = 0;
      quiet = 0;
      hold_rsp = 0;
      price_base = 1000;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_update(SIDE_BID, 32'h0, 32'h0, 1);
      send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'h0, 1);
      send_update(SIDE_BID, 32'h0, 32'hFFFF_FFFF, 0);
      send_update(SIDE_BID, 32'hFFFF_FFFF, 32'h1, 0);
      send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send_update(SIDE_ASK, 32'h0, 32'h5, 1);
      send_update(SIDE_BID, 32'hFFFF_FFFF, 32'h7, 1);
      send_update(SIDE_BID, 32'hFFFF_FFFF, 32'h0, 1);
      send_update(SIDE_ASK, 32'h0, 32'h0, 0);
      send_update(SIDE_ASK, 32'h1234, 32'h0, 1);
      send_update(SIDE_BID, 32'h0, 32'h0, 1);
      send_update(SIDE_ASK, 32'hFFFF_FFFF, 32'h0, 1);

      // fill the bid table, overflow it, then drain
      for (int k = 0; k < 258; k++)
         send_update(SIDE_BID, 32'd5000 + k, $urandom | 1, k >= 255);
      send_update(SIDE_ASK, 32'd7, 32'd9, 1);
      send_update(SIDE_BID, 32'd5003, 32'h0, 0);
      send_update(SIDE_BID, 32'd9999, 32'd3, 1);
      for (int k = 0; k < 258; k++)
         send_update(SIDE_BID, 32'd5000 + k, 32'h0, k % 50 == 0);
      send_update(SIDE_BID, 32'd9999, 32'h0, 1);
      send_update(SIDE_ASK, 32'd7, 32'h0, 1);

      // receiver holds off while updates keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (3000) @(negedge clock);
            hold_rsp = 0;
         end
         for (int k = 0; k < 6; k++)
            send_update(1'($urandom_range(1)), pick_price(), pick_amount(), 1);
      join

      for (int n = 0; n < 1200; n++) begin
         if (n == 300) quiet = 1;
         if (n == 500) quiet = 0;
         if (n % 200 == 0) price_base = $urandom_range(100000);
         send_update(1'($urandom_range(1)), pick_price(), pick_amount(),
                     $urandom_range(3) == 0);
      end
      send_update(SIDE_BID, 32'h0, 32'h0, 1);
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
